### rtl/core/ggc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ggc_pkg: shared types and constants of the gyro gesture classifier
// Gesture codes, shake direction codes, register indexes, reset values and
// the fixed thresholds used by the classification logic.
// ---------------------------------------------------------------------------
package ggc_pkg;

    // Reported gesture codes.
    typedef enum logic [2:0] {
        G_NONE   = 3'd0,
        G_CIRCLE = 3'd1,
        G_SHAKE  = 3'd2,
        G_UP     = 3'd3,
        G_DOWN   = 3'd4,
        G_LEFT   = 3'd5,
        G_RIGHT  = 3'd6
    } gesture_t;

    // Last shake direction seen.
    typedef enum logic [1:0] {
        DIR_NEUTRAL = 2'd0,
        DIR_RIGHT   = 2'd1,
        DIR_LEFT    = 2'd2
    } shake_dir_t;

    // Register indexes (word address on the configuration port).
    localparam logic [2:0] REG_OFFSET_X     = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z     = 3'd2;
    localparam logic [2:0] REG_TILT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_UP_LIMIT     = 3'd4;
    localparam logic [2:0] REG_SHAKE_LIMIT  = 3'd5;
    localparam logic [2:0] REG_CIRCLE_LIMIT = 3'd6;
    localparam logic [2:0] REG_COOLDOWN_MS  = 3'd7;

    // Register reset values.
    localparam logic [15:0] TILT_LIMIT_RST   = 16'd10000;
    localparam logic [15:0] UP_LIMIT_RST     = 16'd5000;
    localparam logic [15:0] SHAKE_LIMIT_RST  = 16'd12000;
    localparam logic [15:0] CIRCLE_LIMIT_RST = 16'd12000;
    localparam logic [15:0] COOLDOWN_MS_RST  = 16'd500;

    // Fixed thresholds.
    localparam logic [15:0] CIRCLE_TILT_MAX = 16'd3000;
    localparam logic [15:0] NEUTRAL_Z_MAX   = 16'd3000;
    localparam int          CIRCLE_HOLD_MS  = 1000;
    localparam int          SHAKE_SPAN_MS   = 2000;
    localparam logic [1:0]  SHAKE_NEEDED    = 2'd2;
    localparam logic [1:0]  ALT_MAX         = 2'd3;

    // One calibrated axis in sign and magnitude form.
    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
    } axis_t;

endpackage

### rtl/core/ggc_axis.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ggc_axis: calibration of one gyro axis
// Subtracts the axis offset from the raw rate and gives the result as a
// sign bit and an exact magnitude for the threshold compares.
// ---------------------------------------------------------------------------
module ggc_axis
    import ggc_pkg::*;
(
    input  logic signed [15:0] raw,
    input  logic signed [15:0] offset,
    output axis_t              axis
);

    logic [16:0] diff;
    logic [16:0] neg_diff;

    // The difference spans -65535..65535, so 17 bits hold it exactly.
    assign diff     = {raw[15], raw} - {offset[15], offset};
    assign neg_diff = 17'd0 - diff;

    // The magnitude never exceeds 65535 and fits in 16 bits.
    assign axis.neg = diff[16];
    assign axis.mag = diff[16] ? neg_diff[15:0] : diff[15:0];

endmodule

### rtl/core/gyro_gesture_classifier_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gyro_gesture_classifier_core: gesture classifier for a 3-axis gyro stream
// Calibrates each sample, applies the global cooldown and detects circle,
// shake and tilt gestures in priority order, reporting changes only.
// ---------------------------------------------------------------------------
//  Channel  | Handshake              | Beat contents
//  ---------+------------------------+--------------------------------------
//  sample   | sample_valid/_stall    | rate_x, rate_y, rate_z, now_ms
//  result   | result_valid/_stall    | gesture, to_cursor
//  config   | APB psel/penable/...   | eight 16-bit registers at 4*index
//
// One sample beat is accepted per cycle while the result is not stalled;
// each gives one result beat through the sample register and then the result
// register. The rate is set by the state update between the two registers.
// A stalled result holds the pipeline; only an empty sample register accepts.
// Reset clears all gesture state at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module gyro_gesture_classifier_core
    import ggc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    input  logic [31:0]        now_ms,

    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         gesture,
    output logic               to_cursor,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers.
    logic signed [15:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic [15:0]        tilt_limit_reg, up_limit_reg, shake_limit_reg;
    logic [15:0]        circle_limit_reg, cooldown_ms_reg;

    // Sample register.
    logic                  s1_valid_reg;
    logic signed [15:0]    s1_x_reg, s1_y_reg, s1_z_reg;
    logic [TIME_BITS-1:0]  s1_now_reg;
    logic [TIME_BITS+31:0] now_wide;

    // Result register.
    logic     result_valid_reg;
    gesture_t gesture_reg;
    logic     to_cursor_reg;

    // Gesture state.
    gesture_t             prev_gesture_reg, prev_gesture_next;
    logic [TIME_BITS-1:0] gesture_time_reg, gesture_time_next;
    logic [TIME_BITS-1:0] circle_time_reg, circle_time_next;
    shake_dir_t           shake_dir_reg, shake_dir_next;
    logic [1:0]           shake_alt_reg, shake_alt_next;
    logic [TIME_BITS-1:0] window_start_reg, window_start_next;

    // Step signals.
    logic     advance;
    logic     step;
    gesture_t report;
    logic     cursor;
    gesture_t cur;
    axis_t    ax, ay, az;

    logic                 cooldown_run;
    logic [TIME_BITS-1:0] el_gesture, el_circle, el_window;
    logic                 circle_hit;
    logic [15:0]          half_limit;
    logic                 neutral;

    shake_dir_t           dir_new, dir1, dir2;
    logic                 flip, expire, shake_hit;
    logic [1:0]           alt1, alt2;
    logic [TIME_BITS-1:0] ws1;

    // The result register moves whenever it is empty or being taken.
    assign advance      = !result_valid_reg || !result_stall;
    assign step         = s1_valid_reg && advance;
    assign sample_stall = s1_valid_reg && !advance;

    assign result_valid = result_valid_reg;
    assign gesture      = gesture_reg;
    assign to_cursor    = to_cursor_reg;
    assign pready       = 1'b1;

    // The timestamp is taken modulo 2^TIME_BITS.
    assign now_wide = {{TIME_BITS{1'b0}}, now_ms};

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
            offset_z_reg     <= '0;
            tilt_limit_reg   <= TILT_LIMIT_RST;
            up_limit_reg     <= UP_LIMIT_RST;
            shake_limit_reg  <= SHAKE_LIMIT_RST;
            circle_limit_reg <= CIRCLE_LIMIT_RST;
            cooldown_ms_reg  <= COOLDOWN_MS_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                REG_OFFSET_X:     offset_x_reg     <= pwdata[15:0];
                REG_OFFSET_Y:     offset_y_reg     <= pwdata[15:0];
                REG_OFFSET_Z:     offset_z_reg     <= pwdata[15:0];
                REG_TILT_LIMIT:   tilt_limit_reg   <= pwdata[15:0];
                REG_UP_LIMIT:     up_limit_reg     <= pwdata[15:0];
                REG_SHAKE_LIMIT:  shake_limit_reg  <= pwdata[15:0];
                REG_CIRCLE_LIMIT: circle_limit_reg <= pwdata[15:0];
                REG_COOLDOWN_MS:  cooldown_ms_reg  <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (paddr[4:2])
            REG_OFFSET_X:     prdata = {16'd0, offset_x_reg};
            REG_OFFSET_Y:     prdata = {16'd0, offset_y_reg};
            REG_OFFSET_Z:     prdata = {16'd0, offset_z_reg};
            REG_TILT_LIMIT:   prdata = {16'd0, tilt_limit_reg};
            REG_UP_LIMIT:     prdata = {16'd0, up_limit_reg};
            REG_SHAKE_LIMIT:  prdata = {16'd0, shake_limit_reg};
            REG_CIRCLE_LIMIT: prdata = {16'd0, circle_limit_reg};
            REG_COOLDOWN_MS:  prdata = {16'd0, cooldown_ms_reg};
            default:          prdata = '0;
        endcase
    end

    // Sample register: loads whenever it is empty or moving on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || advance)
        begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            s1_x_reg   <= rate_x;
            s1_y_reg   <= rate_y;
            s1_z_reg   <= rate_z;
            s1_now_reg <= now_wide[TIME_BITS-1:0];
        end
    end

    // Per-axis calibration.
    ggc_axis u_axis_x (.raw(s1_x_reg), .offset(offset_x_reg), .axis(ax));
    ggc_axis u_axis_y (.raw(s1_y_reg), .offset(offset_y_reg), .axis(ay));
    ggc_axis u_axis_z (.raw(s1_z_reg), .offset(offset_z_reg), .axis(az));

    // Elapsed times and the circle test.
    assign el_gesture   = s1_now_reg - gesture_time_reg;
    assign el_circle    = s1_now_reg - circle_time_reg;
    assign cooldown_run = el_gesture < TIME_BITS'(cooldown_ms_reg);
    assign circle_hit   = (ax.mag < CIRCLE_TILT_MAX) && (ay.mag < CIRCLE_TILT_MAX)
                       && (az.mag > circle_limit_reg)
                       && (el_circle > TIME_BITS'(CIRCLE_HOLD_MS));

    // Neutral sample test against half the tilt limit.
    assign half_limit = {1'b0, tilt_limit_reg[15:1]};
    assign neutral    = (ax.mag < half_limit) && (ay.mag < half_limit)
                     && (az.mag < NEUTRAL_Z_MAX);

    // Shake tracker: count direction changes, expire the window, detect.
    always_comb
    begin
        if (!ax.neg && ax.mag > shake_limit_reg)
            dir_new = DIR_RIGHT;
        else if (ax.neg && ax.mag > shake_limit_reg)
            dir_new = DIR_LEFT;
        else
            dir_new = DIR_NEUTRAL;

        flip = (dir_new != DIR_NEUTRAL) && (dir_new != shake_dir_reg);
        dir1 = flip ? dir_new : shake_dir_reg;
        ws1  = (flip && shake_alt_reg == 2'd0) ? s1_now_reg : window_start_reg;
        if (flip && shake_alt_reg < ALT_MAX)
            alt1 = shake_alt_reg + 2'd1;
        else
            alt1 = shake_alt_reg;

        el_window = s1_now_reg - ws1;
        expire    = (alt1 != 2'd0) && (el_window > TIME_BITS'(SHAKE_SPAN_MS));
        alt2      = expire ? 2'd0 : alt1;
        dir2      = expire ? DIR_NEUTRAL : dir1;
        shake_hit = alt2 >= SHAKE_NEEDED;
    end

    // Classification and next state for the sample in the register.
    always_comb
    begin
        prev_gesture_next = prev_gesture_reg;
        gesture_time_next = gesture_time_reg;
        circle_time_next  = circle_time_reg;
        shake_dir_next    = shake_dir_reg;
        shake_alt_next    = shake_alt_reg;
        window_start_next = window_start_reg;
        cur               = G_NONE;
        report            = G_NONE;
        cursor            = 1'b0;

        if (!cooldown_run)
        begin
            if (circle_hit)
            begin
                cur              = G_CIRCLE;
                circle_time_next = s1_now_reg;
            end
            else
            begin
                window_start_next = ws1;
                shake_dir_next    = shake_hit ? DIR_NEUTRAL : dir2;
                shake_alt_next    = shake_hit ? 2'd0 : alt2;
                if (shake_hit)
                begin
                    cur    = G_SHAKE;
                    cursor = 1'b1;
                end
                else if (!ay.neg && ay.mag > tilt_limit_reg)
                    cur = G_DOWN;
                else if (ay.neg && ay.mag > up_limit_reg)
                    cur = G_UP;
                else if (!ax.neg && ax.mag > tilt_limit_reg)
                    cur = G_RIGHT;
                else if (ax.neg && ax.mag > tilt_limit_reg)
                    cur = G_LEFT;
            end

            // Only a change of gesture is reported and restarts the cooldown.
            if (cur != G_NONE && cur != prev_gesture_reg)
            begin
                report            = cur;
                prev_gesture_next = cur;
                gesture_time_next = s1_now_reg;
            end

            if (neutral)
                prev_gesture_next = G_NONE;
        end
    end

    // Gesture state commits when the sample moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_gesture_reg <= G_NONE;
            gesture_time_reg <= '0;
            circle_time_reg  <= '0;
            shake_dir_reg    <= DIR_NEUTRAL;
            shake_alt_reg    <= 2'd0;
            window_start_reg <= '0;
        end
        else if (step)
        begin
            prev_gesture_reg <= prev_gesture_next;
            gesture_time_reg <= gesture_time_next;
            circle_time_reg  <= circle_time_next;
            shake_dir_reg    <= shake_dir_next;
            shake_alt_reg    <= shake_alt_next;
            window_start_reg <= window_start_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            gesture_reg   <= report;
            to_cursor_reg <= cursor;
        end
    end

endmodule
